// ===== hdl/rdsbs_pkg.sv =====
// shared types, constants and functions for the rds block sync and group decoder
package rdsbs_pkg;

    localparam logic [9:0] SYN_A  = 10'h3D8;
    localparam logic [9:0] SYN_B  = 10'h3D4;
    localparam logic [9:0] SYN_C  = 10'h25C;
    localparam logic [9:0] SYN_CP = 10'h3CC;
    localparam logic [9:0] SYN_D  = 10'h258;

    localparam logic [15:0] TIMEOUT_RESET = 16'd52000;
    localparam logic [3:0]  MAX_ERR_RESET = 4'd4;
    localparam logic [7:0]  SPACE_CHAR    = 8'h20;
    localparam int          BLOCK_BITS    = 26;
    localparam int          TEXT_DEPTH    = 64;

    typedef enum logic [1:0] {
        OP_FEED = 2'd0,
        OP_READ_PS = 2'd1,
        OP_READ_RT = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        OFS_NONE = 3'd0,
        OFS_A = 3'd1,
        OFS_B = 3'd2,
        OFS_C = 3'd3,
        OFS_CP = 3'd4,
        OFS_D = 3'd5
    } offset_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_MAX_ERR = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_PAIR_RD,
        ST_PAIR_WR,
        ST_CLEAR,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       rx_bit;
        logic [5:0] char_index;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pi_code;
        logic [4:0]  pty;
        logic        tp_flag;
        logic        ta_flag;
        logic        locked;
        logic        flip_parity;
        logic        group_done;
        logic [31:0] text_generation;
        logic [31:0] group_count;
        logic [7:0]  char_value;
    } out_item_t;

    typedef struct packed {
        logic       we;
        logic       ps_sel;
        logic [5:0] addr;
        logic [7:0] wdata;
    } mem_req_t;

    function automatic logic [9:0] check_row(input logic [4:0] r);
        logic [9:0] v;
        begin
            case (r)
                5'd0: v = 10'h200;  5'd1: v = 10'h100;  5'd2: v = 10'h080;
                5'd3: v = 10'h040;  5'd4: v = 10'h020;  5'd5: v = 10'h010;
                5'd6: v = 10'h008;  5'd7: v = 10'h004;  5'd8: v = 10'h002;
                5'd9: v = 10'h001;  5'd10: v = 10'h2DC; 5'd11: v = 10'h16E;
                5'd12: v = 10'h0B7; 5'd13: v = 10'h287; 5'd14: v = 10'h39F;
                5'd15: v = 10'h313; 5'd16: v = 10'h355; 5'd17: v = 10'h376;
                5'd18: v = 10'h1BB; 5'd19: v = 10'h201; 5'd20: v = 10'h3DC;
                5'd21: v = 10'h1EE; 5'd22: v = 10'h0F7; 5'd23: v = 10'h2A7;
                5'd24: v = 10'h38F; 5'd25: v = 10'h31B;
                default: v = 10'h000;
            endcase
            return v;
        end
    endfunction

    function automatic logic [9:0] syndrome(input logic [25:0] w);
        logic [9:0] s;
        begin
            s = '0;
            for (int k = 0; k < BLOCK_BITS; k++)
            begin
                if (w[k])
                    s = s ^ check_row(5'(25 - k));
            end
            return s;
        end
    endfunction

    function automatic offset_t offset_of(input logic [9:0] s);
        offset_t o;
        begin
            unique case (s)
                SYN_A: o = OFS_A;
                SYN_B: o = OFS_B;
                SYN_C: o = OFS_C;
                SYN_CP: o = OFS_CP;
                SYN_D: o = OFS_D;
                default: o = OFS_NONE;
            endcase
            return o;
        end
    endfunction

endpackage

// ===== hdl/rdsbs_text_mem.sv =====
// character stores for service name and radiotext with registered read
module rdsbs_text_mem
    import rdsbs_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    input  logic       re,
    output logic [7:0] rdata
);

    logic [7:0] ps_mem [8];
    logic [7:0] rt_mem [TEXT_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            if (req.ps_sel)
                ps_mem[req.addr[2:0]] <= req.wdata;
            else
                rt_mem[req.addr] <= req.wdata;
        end
        if (re)
        begin
            if (req.ps_sel)
                rdata_reg <= ps_mem[req.addr[2:0]];
            else
                rdata_reg <= rt_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rds_block_sync_group_decoder.sv =====
// top level of the rds block synchronizer and group decoder
// usage:
//   in channel (in_valid/in_ready/in_data) carries one opcode per transfer:
//   feed a data bit, read a service name char or read a radiotext char
//   out channel (out_valid/out_ready/out_data) returns exactly one result
//   per input transfer, holding status after that item
//   cfg_we/cfg_index/cfg_data write the timeout and error limit registers
//   throughput: one item at a time; a plain bit or a read passes through
//   its bit or read state and then the output state, and the next item is
//   taken the cycle after the result transfer
//   a bit closing a group first runs a sequencer over the text store: up to
//   4 character read/write pairs, plus a clear of all 64 radiotext entries
//   when the a/b flag toggles
//   after reset a pass fills all 64 radiotext entries and then the 8
//   service name entries with spaces; no item is accepted meanwhile
//   the result sits in an output register; a stalled receiver holds the
//   block, the next item is taken once the result has been transferred
module rds_block_sync_group_decoder
    import rdsbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;
    logic [15:0] timeout_reg;
    logic [3:0]  max_err_reg;
    logic [25:0] shift_reg;
    logic        sync_reg;
    logic [15:0] ucount_reg;
    logic        cand_reg;
    logic [4:0]  cwait_reg;
    logic [15:0] cword_reg;
    logic [4:0]  bib_reg;
    logic [1:0]  slot_reg;
    logic [3:0]  err_reg;
    logic [15:0] gw_reg [4];
    logic [15:0] pi_reg;
    logic [4:0]  pty_reg;
    logic        tp_reg, ta_reg, ab_seen_reg, ab_last_reg;
    logic [31:0] gen_reg, groups_reg;
    logic        flip_reg, done_reg;
    logic [7:0]  char_reg;
    in_item_t    item_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;
    logic        init_reg;
    logic [6:0]  clr_reg;
    logic [2:0]  pair_reg, npairs_reg;
    logic        ps_sel_reg, pair_chg_reg;
    logic        hi_phase_reg;

    mem_req_t    req;
    logic        re;
    logic [7:0]  rdata;

    rdsbs_text_mem u_mem (.clk(clk), .req(req), .re(re), .rdata(rdata));

    // pair bookkeeping: address and data of current character
    logic [5:0]  pair_base;
    logic [15:0] pair_word;
    logic [5:0]  char_addr;
    logic [7:0]  char_data;
    logic [15:0] b_word;

    assign b_word = gw_reg[1];

    always_comb
    begin
        pair_base = '0;
        pair_word = gw_reg[3];
        if (ps_sel_reg)
            pair_base = {3'd0, b_word[1:0], 1'b0};
        else if (!b_word[11])
        begin
            pair_base = {b_word[3:0], pair_reg[0], 1'b0};
            pair_word = pair_reg[0] ? gw_reg[3] : gw_reg[2];
        end
        else
            pair_base = {1'b0, b_word[3:0], 1'b0};
        char_addr = pair_base | {5'd0, ~hi_phase_reg};
        char_data = hi_phase_reg ? pair_word[15:8] : pair_word[7:0];
    end

    // bit processing, computed combinationally in ST_BIT
    logic [25:0] sh_n;
    offset_t     ofs;
    always_comb
    begin
        sh_n = {shift_reg[24:0], item_reg.rx_bit};
        ofs = offset_of(syndrome(sh_n));
    end

    logic       done_seq_start;
    logic       ab_toggle;
    logic [2:0] npairs_start;
    always_comb
    begin
        done_seq_start = (item_reg.opcode == OP_FEED) && sync_reg && (bib_reg == 5'd25)
            && (slot_reg == 2'd3) && (ofs == OFS_D);
        ab_toggle = (b_word[15:12] == 4'd2) && ab_seen_reg && (b_word[4] != ab_last_reg);
        npairs_start = (b_word[15:12] == 4'd0) ? 3'd1
            : (b_word[15:12] == 4'd2) ? (b_word[11] ? 3'd1 : 3'd2) : 3'd0;
    end

    assign in_ready = (state_reg == ST_IDLE) && !init_reg && !out_valid_reg;

    logic accept;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (in_data.opcode == OP_READ_PS || in_data.opcode == OP_READ_RT)
                        state_next = ST_READ;
                    else
                        state_next = ST_BIT;
                end
            ST_BIT:
                if (done_seq_start)
                begin
                    if (ab_toggle)
                        state_next = ST_CLEAR;
                    else if (npairs_start != 3'd0)
                        state_next = ST_PAIR_RD;
                    else
                        state_next = ST_OUT;
                end
                else
                    state_next = ST_OUT;
            ST_READ: state_next = ST_OUT;
            ST_CLEAR:
                if (clr_reg == 7'(TEXT_DEPTH - 1))
                    state_next = (npairs_reg != 3'd0) ? ST_PAIR_RD : ST_OUT;
            ST_PAIR_RD: state_next = ST_PAIR_WR;
            ST_PAIR_WR:
                if (!hi_phase_reg && pair_reg + 3'd1 >= npairs_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAIR_RD;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req = '0;
        re = 1'b0;
        if (init_reg)
        begin
            req.we = 1'b1;
            req.ps_sel = clr_reg[6];
            req.addr = clr_reg[5:0];
            req.wdata = SPACE_CHAR;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    re = accept;
                    req.ps_sel = (in_data.opcode == OP_READ_PS);
                    req.addr = in_data.char_index;
                end
                ST_CLEAR:
                begin
                    req.we = 1'b1;
                    req.addr = clr_reg[5:0];
                    req.wdata = SPACE_CHAR;
                end
                ST_PAIR_RD:
                begin
                    re = 1'b1;
                    req.ps_sel = ps_sel_reg;
                    req.addr = char_addr;
                end
                ST_PAIR_WR:
                begin
                    req.we = (rdata != char_data);
                    req.ps_sel = ps_sel_reg;
                    req.addr = char_addr;
                    req.wdata = char_data;
                end
                default: req = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            timeout_reg <= TIMEOUT_RESET;
            max_err_reg <= MAX_ERR_RESET;
            shift_reg <= '0;
            sync_reg <= 1'b0;
            ucount_reg <= '0;
            cand_reg <= 1'b0;
            cwait_reg <= '0;
            cword_reg <= '0;
            bib_reg <= '0;
            slot_reg <= '0;
            err_reg <= '0;
            for (int i = 0; i < 4; i++)
                gw_reg[i] <= '0;
            pi_reg <= '0;
            pty_reg <= '0;
            tp_reg <= 1'b0;
            ta_reg <= 1'b0;
            ab_seen_reg <= 1'b0;
            ab_last_reg <= 1'b0;
            gen_reg <= '0;
            groups_reg <= '0;
            flip_reg <= 1'b0;
            done_reg <= 1'b0;
            char_reg <= '0;
            item_reg <= '0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
            init_reg <= 1'b1;
            clr_reg <= '0;
            pair_reg <= '0;
            npairs_reg <= '0;
            ps_sel_reg <= 1'b0;
            pair_chg_reg <= 1'b0;
            hi_phase_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT)
                    timeout_reg <= cfg_data;
                else if (cfg_index == CFG_MAX_ERR)
                    max_err_reg <= cfg_data[3:0];
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (init_reg)
            begin
                if (clr_reg == 7'd71)
                begin
                    init_reg <= 1'b0;
                    clr_reg <= '0;
                end
                else
                    clr_reg <= clr_reg + 7'd1;
            end
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        item_reg <= in_data;
                        flip_reg <= 1'b0;
                        done_reg <= 1'b0;
                        char_reg <= '0;
                    end
                ST_READ:
                    if (item_reg.opcode == OP_READ_RT
                        || (item_reg.opcode == OP_READ_PS && item_reg.char_index < 6'd8))
                        char_reg <= rdata;
                ST_BIT:
                    if (item_reg.opcode == OP_FEED)
                    begin : feed_blk
                        logic        cp, sy;
                        logic [15:0] uc;
                        logic [4:0]  cw;
                        logic [3:0]  er;
                        logic [1:0]  sl;
                        cp = cand_reg;
                        sy = sync_reg;
                        cw = cwait_reg;
                        shift_reg <= sh_n;
                        if (!sync_reg)
                        begin
                            uc = ucount_reg + 16'd1;
                            if (uc >= timeout_reg)
                            begin
                                uc = '0;
                                flip_reg <= 1'b1;
                                cp = 1'b0;
                            end
                            if (cp)
                            begin
                                cw = cw - 5'd1;
                                if (cw == 5'd0)
                                begin
                                    if (ofs == OFS_B)
                                    begin
                                        sy = 1'b1;
                                        gw_reg[0] <= cword_reg;
                                        gw_reg[1] <= sh_n[25:10];
                                        slot_reg <= 2'd2;
                                        err_reg <= '0;
                                        bib_reg <= '0;
                                        uc = '0;
                                    end
                                    cp = 1'b0;
                                end
                            end
                            if (!sy && !cp && ofs == OFS_A)
                            begin
                                cp = 1'b1;
                                cw = 5'd26;
                                cword_reg <= sh_n[25:10];
                            end
                            ucount_reg <= uc;
                            cand_reg <= cp;
                            cwait_reg <= cw;
                            sync_reg <= sy;
                        end
                        else if (bib_reg != 5'd25)
                            bib_reg <= bib_reg + 5'd1;
                        else
                        begin
                            bib_reg <= '0;
                            sl = slot_reg;
                            if ((sl == 2'd0 && ofs == OFS_A) || (sl == 2'd1 && ofs == OFS_B)
                                || (sl == 2'd2 && (ofs == OFS_C || ofs == OFS_CP))
                                || (sl == 2'd3 && ofs == OFS_D))
                            begin
                                gw_reg[sl] <= sh_n[25:10];
                                err_reg <= '0;
                                slot_reg <= sl + 2'd1;
                                if (sl == 2'd3)
                                begin
                                    done_reg <= 1'b1;
                                    pi_reg <= gw_reg[0];
                                    pty_reg <= b_word[9:5];
                                    tp_reg <= b_word[10];
                                    groups_reg <= groups_reg + 32'd1;
                                    pair_reg <= '0;
                                    hi_phase_reg <= 1'b1;
                                    pair_chg_reg <= 1'b0;
                                    clr_reg <= '0;
                                    ps_sel_reg <= (b_word[15:12] == 4'd0);
                                    npairs_reg <= npairs_start;
                                    if (ab_toggle)
                                        gen_reg <= gen_reg + 32'd1;
                                    if (b_word[15:12] == 4'd0)
                                        ta_reg <= b_word[4];
                                    else if (b_word[15:12] == 4'd2)
                                    begin
                                        ab_seen_reg <= 1'b1;
                                        ab_last_reg <= b_word[4];
                                    end
                                end
                            end
                            else
                            begin
                                er = (err_reg < 4'd15) ? err_reg + 4'd1 : err_reg;
                                err_reg <= er;
                                if (er >= max_err_reg)
                                begin
                                    sync_reg <= 1'b0;
                                    cand_reg <= 1'b0;
                                    slot_reg <= '0;
                                    ucount_reg <= '0;
                                end
                            end
                        end
                    end
                ST_CLEAR:
                    clr_reg <= clr_reg + 7'd1;
                ST_PAIR_WR:
                begin
                    hi_phase_reg <= ~hi_phase_reg;
                    if (!hi_phase_reg)
                    begin
                        pair_reg <= pair_reg + 3'd1;
                        pair_chg_reg <= 1'b0;
                        if (pair_chg_reg || rdata != char_data)
                            gen_reg <= gen_reg + 32'd1;
                    end
                    else
                        pair_chg_reg <= (rdata != char_data);
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg.pi_code <= pi_reg;
                    out_reg.pty <= pty_reg;
                    out_reg.tp_flag <= tp_reg;
                    out_reg.ta_flag <= ta_reg;
                    out_reg.locked <= sync_reg;
                    out_reg.flip_parity <= flip_reg;
                    out_reg.group_done <= done_reg;
                    out_reg.text_generation <= gen_reg;
                    out_reg.group_count <= groups_reg;
                    out_reg.char_value <= char_reg;
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule
